// ----- design/csvtok_pkg.sv -----
// Shared types, character codes and register map for the CSV field tokenizer.
package csvtok_pkg;

  // Character codes with a fixed meaning in the text
  localparam logic [7:0] QUOTE_CH = 8'h22;
  localparam logic [7:0] LF_CH    = 8'h0A;
  localparam logic [7:0] CR_CH    = 8'h0D;
  localparam logic [7:0] NUL_CH   = 8'h00;

  // Register reset values
  localparam logic [7:0] DELIM_RESET  = 8'd44;
  localparam logic       QAWARE_RESET = 1'b1;

  // APB address width: two word-aligned registers
  localparam int unsigned ADDR_W = 3;

  // Register index, taken from the word address
  typedef enum logic [0:0] {
    REG_DELIM  = 1'b0,
    REG_QAWARE = 1'b1
  } reg_idx_e;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_CHAR          = 2'd0,
    KIND_FIELD_END     = 2'd1,
    KIND_FIELD_REC_END = 2'd2,
    KIND_REC_END       = 2'd3
  } kind_e;

  // Configuration seen by the tokenizer core
  typedef struct packed {
    logic [7:0] delimiter;
    logic       quote_aware;
  } cfg_t;

  // One result beat
  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
  } res_t;

  // Per-record parse state
  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic swallow_next;
    logic record_started;
    logic field_nonempty;
    logic fields_cut;
  } state_t;

endpackage

// ----- design/csv_record_field_tokenizer.sv -----
// CSV tokenizer: byte in, field characters and field/record marks out.
// An accepted byte's result beat passes the input and then the output register.
// Throughput: one byte per cycle; s_axis_tready falls only while both the input
// register and the output register hold beats and m_axis_tready is low.
// Reset (rst_ni low, asynchronous): parse state and valid flags clear, the
// delimiter returns to ',' and quote-aware records to on; no clearing pass.
module csv_record_field_tokenizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csvtok_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
  input  logic                          s_axis_tuser,   // [0] stream_end
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [7:0]                    m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]                    m_axis_tuser    // [1:0] kind
);

  csvtok_pkg::cfg_t cfg;
  csvtok_pkg::res_t res;
  logic             res_valid;
  logic             res_ready;

  csvtok_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  csvtok_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .in_end_i    (s_axis_tuser),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  csvtok_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .res_valid_i   (res_valid),
    .res_ready_o   (res_ready),
    .res_i         (res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ----- design/csvtok_cfg.sv -----
// APB register file holding the delimiter and the record mode.
module csvtok_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [csvtok_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  output csvtok_pkg::cfg_t                 cfg_o
);

  logic [7:0]           delim_q;
  logic                 qaware_q;
  logic                 wr_en;
  csvtok_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = csvtok_pkg::reg_idx_e'(paddr[csvtok_pkg::ADDR_W-1:2]);

  // Write registers in the access phase
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q  <= csvtok_pkg::DELIM_RESET;
      qaware_q <= csvtok_pkg::QAWARE_RESET;
    end else if (wr_en) begin
      case (idx)
        csvtok_pkg::REG_DELIM:  delim_q  <= pwdata[7:0];
        csvtok_pkg::REG_QAWARE: qaware_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    case (idx)
      csvtok_pkg::REG_DELIM:  prdata = {24'd0, delim_q};
      csvtok_pkg::REG_QAWARE: prdata = {31'd0, qaware_q};
      default:                prdata = 32'd0;
    endcase
  end

  assign cfg_o.delimiter   = delim_q;
  assign cfg_o.quote_aware = qaware_q;

endmodule

// ----- design/csvtok_core.sv -----
// Input register, parse state and one-byte tokenizing step.
module csvtok_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csvtok_pkg::cfg_t  cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_end_i,
  output logic              res_valid_o,
  output csvtok_pkg::res_t  res_o,
  input  logic              res_ready_i
);

  logic               s1_valid_q;
  logic [7:0]         s1_byte_q;
  logic               s1_end_q;
  csvtok_pkg::state_t st_q, st_d;
  logic               proc;
  logic               emit;
  csvtok_pkg::res_t   res;

  // Stage moves when empty or when the result side takes its beat
  assign proc       = s1_valid_q & res_ready_i;
  assign in_ready_o = ~s1_valid_q | res_ready_i;

  // Hold the accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_byte_q <= in_byte_i;
      s1_end_q  <= in_end_i;
    end
  end

  // Tokenizing step: next state and optional result
  always_comb begin
    logic is_nl;
    logic iq_eff;
    logic fn_eff;
    st_d         = st_q;
    emit         = 1'b0;
    res.kind     = csvtok_pkg::KIND_CHAR;
    res.out_byte = 8'd0;
    is_nl  = (s1_byte_q == csvtok_pkg::CR_CH) || (s1_byte_q == csvtok_pkg::LF_CH);
    iq_eff = st_q.in_quotes;
    fn_eff = st_q.field_nonempty;
    if (s1_end_q) begin
      // Close any open record and return to reset
      if (st_q.record_started) begin
        emit     = 1'b1;
        res.kind = (st_q.field_nonempty || (st_q.quote_pending && !st_q.fields_cut)) ?
                   csvtok_pkg::KIND_FIELD_REC_END : csvtok_pkg::KIND_REC_END;
      end
      st_d = '0;
    end else if (st_q.swallow_next && is_nl) begin
      // Drop the second half of a newline pair
      st_d.swallow_next = 1'b0;
    end else if (is_nl && (!cfg_i.quote_aware || !st_q.in_quotes || st_q.quote_pending)) begin
      // Record-ending newline
      if (st_q.record_started) begin
        emit     = 1'b1;
        res.kind = (st_q.field_nonempty || (st_q.quote_pending && !st_q.fields_cut)) ?
                   csvtok_pkg::KIND_FIELD_REC_END : csvtok_pkg::KIND_REC_END;
      end
      st_d              = '0;
      st_d.swallow_next = 1'b1;
    end else begin
      st_d.swallow_next   = 1'b0;
      st_d.record_started = 1'b1;
      if (st_q.quote_pending && s1_byte_q == csvtok_pkg::QUOTE_CH) begin
        // Doubled quote inside quotes
        st_d.quote_pending = 1'b0;
        if (!st_q.fields_cut) begin
          emit                = 1'b1;
          res.out_byte        = csvtok_pkg::QUOTE_CH;
          st_d.field_nonempty = 1'b1;
        end
      end else begin
        if (st_q.quote_pending) begin
          // Previous quote closed the quoted section
          iq_eff = 1'b0;
          if (s1_byte_q == csvtok_pkg::NUL_CH && !st_q.fields_cut) begin
            fn_eff = 1'b1;
          end
        end
        st_d.quote_pending  = 1'b0;
        st_d.in_quotes      = iq_eff;
        st_d.field_nonempty = fn_eff;
        if (s1_byte_q == csvtok_pkg::NUL_CH) begin
          st_d.fields_cut = 1'b1;
        end else if (s1_byte_q == csvtok_pkg::QUOTE_CH) begin
          if (iq_eff) begin
            st_d.quote_pending = 1'b1;
          end else begin
            st_d.in_quotes = 1'b1;
          end
        end else if (st_q.fields_cut) begin
          // Cut record: no output
        end else if (!iq_eff && s1_byte_q == cfg_i.delimiter) begin
          emit                = 1'b1;
          res.kind            = csvtok_pkg::KIND_FIELD_END;
          st_d.field_nonempty = 1'b0;
        end else begin
          emit                = 1'b1;
          res.out_byte        = is_nl ? csvtok_pkg::LF_CH : s1_byte_q;
          st_d.field_nonempty = 1'b1;
        end
      end
    end
  end

  // Advance parse state once per processed beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (proc) begin
      st_q <= st_d;
    end
  end

  assign res_valid_o = proc & emit;
  assign res_o       = res;

  // A processed stream end leaves the parse state at reset
  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && s1_end_q |=> st_q == '0)
    else $error("stream end did not clear parse state");

  // A pending quote only exists inside quotes
  a_qp_in_quotes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.quote_pending |-> st_q.in_quotes)
    else $error("quote pending outside quotes");

  // A cut record has started
  a_cut_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q.fields_cut |-> st_q.record_started)
    else $error("fields cut without a started record");

  // Nothing leaves without a processed beat
  a_res_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> s1_valid_q && res_ready_i)
    else $error("result without a processed beat");

endmodule

// ----- design/csvtok_obuf.sv -----
// Output register for result beats toward the master stream.
module csvtok_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              res_valid_i,
  output logic              res_ready_o,
  input  csvtok_pkg::res_t  res_i,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,
  output logic [1:0]        m_axis_tuser
);

  logic             valid_q;
  csvtok_pkg::res_t res_q;

  assign res_ready_o = ~valid_q | m_axis_tready;

  // Load a new beat when the register is free or draining
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (res_ready_o) begin
      valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = res_q.out_byte;
  assign m_axis_tuser  = res_q.kind;

endmodule
